// ===== src/tpo_pkg.sv =====
// Shared constants, codes and types for the two-opt tour adjacency engine.
`timescale 1ns / 1ps
`default_nettype none
package tpo_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int PT_W       = $clog2(MAX_POINTS);
	localparam int ADJ_W      = PT_W + 1;
	localparam int ROW_W      = 2 * ADJ_W;
	localparam int CNT_W      = 11;
	localparam int STEP_W     = PT_W + 1;

	localparam logic [ADJ_W-1:0] NO_POINT = '1;
	localparam logic [ROW_W-1:0] ROW_INV  = '1;
	localparam logic [CNT_W-1:0] CNT_MAX  = '1;
	localparam logic [PT_W-1:0]  LAST_PT  = PT_W'(MAX_POINTS - 1);

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_MOVE  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_SLOT = 2'd1;
	localparam logic [1:0] ST_NO_PRED = 2'd2;

	typedef struct packed {
		logic [1:0]      opcode;
		logic [PT_W-1:0] point_a;
		logic [PT_W-1:0] point_b;
		logic            last_point;
	} cmd_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [PT_W-1:0] next_point;
		logic [PT_W-1:0] prev_point;
	} rsp_t;

	typedef struct packed {
		logic             we;
		logic [PT_W-1:0]  waddr;
		logic [ROW_W-1:0] wdata;
		logic [PT_W-1:0]  raddr;
	} adj_req_t;

	typedef struct packed {
		logic            we;
		logic [PT_W-1:0] waddr;
		logic [PT_W-1:0] wdata;
		logic [PT_W-1:0] raddr;
	} succ_req_t;

endpackage
`default_nettype wire

// ===== src/tpo_ram.sv =====
// Generic single-clock memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tpo_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/tpo_seq.sv =====
// Sequencer that runs load, move, query and successor rebuild over the two memories.
`timescale 1ns / 1ps
`default_nettype none
module tpo_seq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire tpo_pkg::cmd_t             cmd,
	output logic                           busy,
	output logic                           done,
	output tpo_pkg::rsp_t                  rsp,
	output tpo_pkg::adj_req_t              adj_req,
	input  wire logic [tpo_pkg::ROW_W-1:0] adj_rdata,
	output tpo_pkg::succ_req_t             succ_req,
	input  wire logic [tpo_pkg::PT_W-1:0]  succ_rdata
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_ADJ_RD = 4'd2;
	localparam logic [3:0] S_ADJ_WR = 4'd3;
	localparam logic [3:0] S_MV_RDA = 4'd4;
	localparam logic [3:0] S_MV_RDB = 4'd5;
	localparam logic [3:0] S_MV_CAP = 4'd6;
	localparam logic [3:0] S_Q_RD   = 4'd7;
	localparam logic [3:0] S_Q_EVAL = 4'd8;
	localparam logic [3:0] S_RB0_RD = 4'd9;
	localparam logic [3:0] S_RB0_WR = 4'd10;
	localparam logic [3:0] S_RB_RD  = 4'd11;
	localparam logic [3:0] S_RB_WR  = 4'd12;

	localparam logic [1:0] K_FILL  = 2'd0;
	localparam logic [1:0] K_CLEAR = 2'd1;
	localparam logic [1:0] K_SWAP  = 2'd2;

	logic [3:0]                   state_q;
	logic [1:0]                   op_q;
	logic [tpo_pkg::PT_W-1:0]     opa_q;
	logic [tpo_pkg::PT_W-1:0]     opb_q;
	logic                         last_q;
	logic                         cnt_nz_q;
	logic [tpo_pkg::PT_W-1:0]     first_q;
	logic [tpo_pkg::PT_W-1:0]     prev_q;
	logic [tpo_pkg::CNT_W-1:0]    cnt_q;
	logic [tpo_pkg::PT_W-1:0]     na_q;
	logic [tpo_pkg::PT_W-1:0]     nb_q;
	logic [3:0]                   step_q;
	logic [tpo_pkg::PT_W-1:0]     cur_q;
	logic [tpo_pkg::PT_W-1:0]     prv_q;
	logic [tpo_pkg::STEP_W-1:0]   steps_q;
	logic [tpo_pkg::PT_W-1:0]     clr_q;
	logic                         done_q;
	tpo_pkg::rsp_t                rsp_q;

	logic                         m_en;
	logic                         m_end;
	logic [1:0]                   m_kind;
	logic [tpo_pkg::PT_W-1:0]     m_row;
	logic [tpo_pkg::PT_W-1:0]     m_val;

	logic [tpo_pkg::ADJ_W-1:0]    s0;
	logic [tpo_pkg::ADJ_W-1:0]    s1;
	logic [tpo_pkg::ADJ_W-1:0]    val_ext;
	logic [tpo_pkg::ADJ_W-1:0]    prv_ext;
	logic [tpo_pkg::ADJ_W-1:0]    nxt_ext;
	logic [tpo_pkg::ADJ_W-1:0]    oth;
	logic [tpo_pkg::ADJ_W-1:0]    cand;
	logic [tpo_pkg::ROW_W-1:0]    upd_row;
	logic                         fill_fail;
	logic [tpo_pkg::STEP_W-1:0]   steps_nxt;

	assign s0        = adj_rdata[tpo_pkg::ADJ_W-1:0];
	assign s1        = adj_rdata[tpo_pkg::ROW_W-1:tpo_pkg::ADJ_W];
	assign val_ext   = {1'b0, m_val};
	assign prv_ext   = {1'b0, prv_q};
	assign nxt_ext   = {1'b0, succ_rdata};
	assign oth       = (s0 == prv_ext) ? s1 : s0;
	assign steps_nxt = steps_q + 1'b1;

	always_comb begin
		m_en   = 1'b1;
		m_end  = 1'b0;
		m_kind = K_FILL;
		m_row  = opa_q;
		m_val  = opb_q;
		if (op_q == tpo_pkg::OP_LOAD) begin
			case (step_q)
				4'd0: begin
					m_en = cnt_nz_q;
				end
				4'd1: begin
					m_row = opb_q;
					m_val = opa_q;
					m_en  = cnt_nz_q;
				end
				4'd2: begin
					m_row = first_q;
					m_val = opa_q;
					m_en  = last_q;
				end
				4'd3: begin
					m_val = first_q;
					m_en  = last_q;
				end
				4'd4: begin
					m_kind = K_SWAP;
					m_row  = first_q;
					m_en   = last_q && (first_q != opa_q);
				end
				4'd5: begin
					m_kind = K_SWAP;
					m_en   = last_q && (first_q != opa_q);
				end
				default: begin
					m_end = 1'b1;
				end
			endcase
		end else begin
			case (step_q)
				4'd0: begin
					m_kind = K_CLEAR;
					m_val  = na_q;
				end
				4'd1: begin
					m_kind = K_CLEAR;
					m_row  = na_q;
					m_val  = opa_q;
				end
				4'd2: begin
					m_kind = K_CLEAR;
					m_row  = opb_q;
					m_val  = nb_q;
				end
				4'd3: begin
					m_kind = K_CLEAR;
					m_row  = nb_q;
					m_val  = opb_q;
				end
				4'd4: begin
				end
				4'd5: begin
					m_row = opb_q;
					m_val = opa_q;
				end
				4'd6: begin
					m_row = na_q;
					m_val = nb_q;
				end
				4'd7: begin
					m_row = nb_q;
					m_val = na_q;
				end
				default: begin
					m_end = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		upd_row   = adj_rdata;
		fill_fail = 1'b0;
		case (m_kind)
			K_FILL: begin
				if (s0 == tpo_pkg::NO_POINT) begin
					upd_row = {s1, val_ext};
				end else if (s1 == tpo_pkg::NO_POINT) begin
					upd_row = {val_ext, s0};
				end else begin
					fill_fail = 1'b1;
				end
			end
			K_CLEAR: begin
				upd_row = {(s1 == val_ext) ? tpo_pkg::NO_POINT : s1,
					(s0 == val_ext) ? tpo_pkg::NO_POINT : s0};
			end
			K_SWAP: begin
				upd_row = {s0, s1};
			end
			default: begin
				upd_row = adj_rdata;
			end
		endcase
	end

	always_comb begin
		if (s0 == nxt_ext) begin
			cand = s1;
		end else if (s1 == nxt_ext) begin
			cand = s0;
		end else begin
			cand = tpo_pkg::NO_POINT;
		end
	end

	always_comb begin
		adj_req        = '0;
		adj_req.raddr  = opa_q;
		succ_req       = '0;
		succ_req.raddr = opa_q;
		case (state_q)
			S_CLEAR: begin
				adj_req.we    = 1'b1;
				adj_req.waddr = clr_q;
				adj_req.wdata = tpo_pkg::ROW_INV;
			end
			S_ADJ_RD: begin
				adj_req.raddr = m_row;
			end
			S_ADJ_WR: begin
				adj_req.raddr = m_row;
				adj_req.we    = !fill_fail;
				adj_req.waddr = m_row;
				adj_req.wdata = upd_row;
			end
			S_MV_RDB: begin
				succ_req.raddr = opb_q;
			end
			S_RB0_RD: begin
				adj_req.raddr = '0;
			end
			S_RB0_WR: begin
				succ_req.we    = !s0[tpo_pkg::ADJ_W-1];
				succ_req.waddr = '0;
				succ_req.wdata = s0[tpo_pkg::PT_W-1:0];
			end
			S_RB_RD: begin
				adj_req.raddr = cur_q;
			end
			S_RB_WR: begin
				adj_req.raddr  = cur_q;
				succ_req.we    = !oth[tpo_pkg::ADJ_W-1];
				succ_req.waddr = cur_q;
				succ_req.wdata = oth[tpo_pkg::PT_W-1:0];
			end
			default: begin
				adj_req.raddr = opa_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			op_q     <= tpo_pkg::OP_NOP;
			last_q   <= 1'b0;
			cnt_nz_q <= 1'b0;
			first_q  <= '0;
			prev_q   <= '0;
			cnt_q    <= '0;
			step_q   <= '0;
			steps_q  <= '0;
			clr_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == tpo_pkg::LAST_PT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q     <= cmd.opcode;
						opa_q    <= cmd.point_a;
						opb_q    <= (cmd.opcode == tpo_pkg::OP_LOAD) ? prev_q : cmd.point_b;
						last_q   <= cmd.last_point;
						cnt_nz_q <= (cnt_q != '0);
						step_q   <= '0;
						rsp_q    <= '0;
						case (cmd.opcode)
							tpo_pkg::OP_LOAD: begin
								if (cnt_q == '0) begin
									first_q <= cmd.point_a;
								end
								prev_q <= cmd.point_a;
								if (cmd.last_point) begin
									cnt_q <= '0;
								end else if (cnt_q != tpo_pkg::CNT_MAX) begin
									cnt_q <= cnt_q + 1'b1;
								end
								state_q <= S_ADJ_RD;
							end
							tpo_pkg::OP_MOVE: begin
								state_q <= S_MV_RDA;
							end
							tpo_pkg::OP_QUERY: begin
								state_q <= S_Q_RD;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_ADJ_RD: begin
					if (m_end) begin
						if (op_q == tpo_pkg::OP_MOVE || last_q) begin
							state_q <= S_RB0_RD;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end else if (m_en) begin
						state_q <= S_ADJ_WR;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_ADJ_WR: begin
					if (fill_fail) begin
						rsp_q.status <= tpo_pkg::ST_NO_SLOT;
						state_q      <= S_IDLE;
						done_q       <= 1'b1;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_ADJ_RD;
					end
				end
				S_MV_RDA: begin
					state_q <= S_MV_RDB;
				end
				S_MV_RDB: begin
					na_q    <= succ_rdata;
					state_q <= S_MV_CAP;
				end
				S_MV_CAP: begin
					nb_q    <= succ_rdata;
					state_q <= S_ADJ_RD;
				end
				S_Q_RD: begin
					state_q <= S_Q_EVAL;
				end
				S_Q_EVAL: begin
					rsp_q.next_point <= succ_rdata;
					if (cand[tpo_pkg::ADJ_W-1]) begin
						rsp_q.status <= tpo_pkg::ST_NO_PRED;
					end else begin
						rsp_q.prev_point <= cand[tpo_pkg::PT_W-1:0];
					end
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_RB0_RD: begin
					state_q <= S_RB0_WR;
				end
				S_RB0_WR: begin
					if (s0[tpo_pkg::ADJ_W-1]) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						cur_q   <= s0[tpo_pkg::PT_W-1:0];
						prv_q   <= '0;
						steps_q <= '0;
						state_q <= S_RB_RD;
					end
				end
				S_RB_RD: begin
					state_q <= S_RB_WR;
				end
				S_RB_WR: begin
					if (oth[tpo_pkg::ADJ_W-1] || cur_q == '0
						|| steps_nxt == tpo_pkg::STEP_W'(tpo_pkg::MAX_POINTS)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						steps_q <= steps_nxt;
						prv_q   <= cur_q;
						cur_q   <= oth[tpo_pkg::PT_W-1:0];
						state_q <= S_RB_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

// ===== src/tour_two_opt_adjacency_engine_core.sv =====
// Top level of the two-opt tour adjacency engine: sequencer and its two memories.
//
// An item is taken on a rising edge where start is high and busy is low. The
// cmd struct carries the opcode (load point, two-opt move, query, no-op), the
// two points and the last-point flag. Every item gives exactly one result:
// done is high for one cycle with status, next_point and prev_point on rsp,
// and the receiver cannot hold it off. busy is low in that same cycle, so the
// next item can be taken right away. One item is worked on at a time.
// A query, a no-op and a load that does not close the tour leave the successor
// table as it is. A closing load or a move whose slot fills all succeed
// rebuilds the successor table by walking the tour from point 0, one point at
// a time through the single read port of the adjacency memory.
// After reset busy stays high while the adjacency memory is swept to the
// invalid marker, one row per cycle. The successor memory is not cleared and
// must be written by a closed tour before a move or query.
`timescale 1ns / 1ps
`default_nettype none
module tour_two_opt_adjacency_engine_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire tpo_pkg::cmd_t cmd,
	output logic               busy,
	output logic               done,
	output tpo_pkg::rsp_t      rsp
);

	tpo_pkg::adj_req_t          adj_req;
	tpo_pkg::succ_req_t         succ_req;
	logic [tpo_pkg::ROW_W-1:0]  adj_rdata;
	logic [tpo_pkg::PT_W-1:0]   succ_rdata;

	tpo_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.rsp        (rsp),
		.adj_req    (adj_req),
		.adj_rdata  (adj_rdata),
		.succ_req   (succ_req),
		.succ_rdata (succ_rdata)
	);

	tpo_ram #(
		.DEPTH (tpo_pkg::MAX_POINTS),
		.WIDTH (tpo_pkg::ROW_W)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_req.we),
		.waddr (adj_req.waddr),
		.wdata (adj_req.wdata),
		.raddr (adj_req.raddr),
		.rdata (adj_rdata)
	);

	tpo_ram #(
		.DEPTH (tpo_pkg::MAX_POINTS),
		.WIDTH (tpo_pkg::PT_W)
	) u_succ_ram (
		.clk   (clk),
		.we    (succ_req.we),
		.waddr (succ_req.waddr),
		.wdata (succ_req.wdata),
		.raddr (succ_req.raddr),
		.rdata (succ_rdata)
	);

endmodule
`default_nettype wire

// ===== src/tpo_chk.sv =====
// Port-level checker for the two-opt tour adjacency engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tpo_chk (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire tpo_pkg::rsp_t rsp
);

	a_accept_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("Accepted item neither started work nor finished.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result strobe while the block is busy.");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("Result strobe without an item in work.");

	a_slot_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == tpo_pkg::ST_NO_SLOT) |->
			(rsp.next_point == '0 && rsp.prev_point == '0))
		else $error("Slot failure carries nonzero points.");

	a_no_pred_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == tpo_pkg::ST_NO_PRED) |-> (rsp.prev_point == '0))
		else $error("Undeterminable predecessor carries a nonzero point.");

endmodule

bind tour_two_opt_adjacency_engine_core tpo_chk u_chk (.*);
`default_nettype wire

// ===== verif/tb_tour_two_opt_adjacency_engine_core.sv =====
// Self-checking testbench for the two-opt tour adjacency engine core.
`timescale 1ns / 1ps
module tb_tour_two_opt_adjacency_engine_core;
	import tpo_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	tour_two_opt_adjacency_engine_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	logic [ADJ_W-1:0] adj_lo [MAX_POINTS];
	logic [ADJ_W-1:0] adj_hi [MAX_POINTS];
	logic [PT_W-1:0]  succ_of [MAX_POINTS];
	bit               succ_known [MAX_POINTS];
	logic [CNT_W-1:0] load_cnt;
	int               tour_head;
	int               tour_prev;

	rsp_t awaited_rsp [$];
	rsp_t oldest_rsp;
	int   mismatches = 0;
	int   ring [$];
	bit   on_ring [MAX_POINTS];
	bit   idle_on = 1'b1;

	function automatic bit fill_adj(int pt, int nb);
		if (adj_lo[pt] == NO_POINT) begin
			adj_lo[pt] = ADJ_W'(nb);
			return 1'b1;
		end
		if (adj_hi[pt] == NO_POINT) begin
			adj_hi[pt] = ADJ_W'(nb);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit join_pair(int p, int q);
		if (!fill_adj(p, q))
			return 1'b0;
		return fill_adj(q, p);
	endfunction

	function automatic void split_pair(int p, int q);
		if (adj_lo[p] == ADJ_W'(q))
			adj_lo[p] = NO_POINT;
		if (adj_hi[p] == ADJ_W'(q))
			adj_hi[p] = NO_POINT;
		if (adj_lo[q] == ADJ_W'(p))
			adj_lo[q] = NO_POINT;
		if (adj_hi[q] == ADJ_W'(p))
			adj_hi[q] = NO_POINT;
	endfunction

	function automatic void swap_adj(int p);
		logic [ADJ_W-1:0] t;
		t = adj_lo[p];
		adj_lo[p] = adj_hi[p];
		adj_hi[p] = t;
	endfunction

	// Walks the ring from point 0 and rewrites the successor of every point it passes.
	function automatic void walk_tour();
		int cur;
		int prv;
		logic [ADJ_W-1:0] oth;
		if (adj_lo[0] >= MAX_POINTS)
			return;
		succ_of[0] = adj_lo[0][PT_W-1:0];
		succ_known[0] = 1'b1;
		cur = 0;
		for (int steps = 0; steps < MAX_POINTS; steps++) begin
			prv = cur;
			cur = succ_of[cur];
			oth = (adj_lo[cur] == ADJ_W'(prv)) ? adj_hi[cur] : adj_lo[cur];
			if (oth >= MAX_POINTS)
				return;
			succ_of[cur] = oth[PT_W-1:0];
			succ_known[cur] = 1'b1;
			if (cur == 0)
				return;
		end
	endfunction

	function automatic rsp_t tour_response(cmd_t c);
		rsp_t r;
		bit ok;
		int a;
		int b;
		int na;
		int nb;
		logic [ADJ_W-1:0] cand;
		r = '0;
		a = c.point_a;
		b = c.point_b;
		case (c.opcode)
		OP_LOAD: begin
			ok = 1'b1;
			if (load_cnt == '0)
				tour_head = a;
			else
				ok = join_pair(a, tour_prev);
			if (c.last_point) begin
				if (ok)
					ok = join_pair(tour_head, a);
				if (ok) begin
					if (tour_head != a) begin
						swap_adj(tour_head);
						swap_adj(a);
					end
					walk_tour();
				end
				load_cnt = '0;
			end else if (load_cnt != CNT_MAX) begin
				load_cnt = load_cnt + 1'b1;
			end
			tour_prev = a;
			if (!ok)
				r.status = ST_NO_SLOT;
		end
		OP_MOVE: begin
			na = succ_of[a];
			nb = succ_of[b];
			split_pair(a, na);
			split_pair(b, nb);
			ok = join_pair(a, b);
			if (ok)
				ok = join_pair(na, nb);
			if (ok)
				walk_tour();
			else
				r.status = ST_NO_SLOT;
		end
		OP_QUERY: begin
			r.next_point = succ_of[a];
			cand = NO_POINT;
			if (adj_lo[a] == {1'b0, r.next_point})
				cand = adj_hi[a];
			else if (adj_hi[a] == {1'b0, r.next_point})
				cand = adj_lo[a];
			if (cand >= MAX_POINTS)
				r.status = ST_NO_PRED;
			else
				r.prev_point = cand[PT_W-1:0];
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result: status %0d next %0d prev %0d",
						$realtime, rsp.status, rsp.next_point, rsp.prev_point);
			end else begin
				oldest_rsp = awaited_rsp.pop_front();
				if (rsp.status !== oldest_rsp.status ||
						rsp.next_point !== oldest_rsp.next_point ||
						rsp.prev_point !== oldest_rsp.prev_point) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected status %0d next %0d prev %0d, got %0d %0d %0d",
							$realtime, oldest_rsp.status, oldest_rsp.next_point,
							oldest_rsp.prev_point, rsp.status, rsp.next_point, rsp.prev_point);
				end
			end
		end
	end

	task automatic send_item(logic [1:0] op, int a, int b, bit last);
		cmd_t item;
		rsp_t expected;
		item.opcode = op;
		item.point_a = a[PT_W-1:0];
		item.point_b = b[PT_W-1:0];
		item.last_point = last;
		if (idle_on) begin
			while ($urandom_range(99) < 30) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		cmd <= item;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		expected = tour_response(item);
		awaited_rsp = {awaited_rsp, expected};
	endtask

	task automatic await_all_results();
		start <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic int ring_point();
		return ring[$urandom_range(ring.size() - 1)];
	endfunction

	function automatic int known_point();
		int p;
		p = $urandom_range(MAX_POINTS - 1);
		while (!succ_known[p])
			p = $urandom_range(MAX_POINTS - 1);
		return p;
	endfunction

	function automatic int fresh_point();
		int p;
		p = $urandom_range(MAX_POINTS - 1);
		while (on_ring[p])
			p = $urandom_range(MAX_POINTS - 1);
		return p;
	endfunction

	function automatic bit move_ok(int a, int b);
		return a != b && b != succ_of[a] && a != succ_of[b];
	endfunction

	task automatic test_tour_load();
		int p;
		int j;
		int t;
		ring = '{0, MAX_POINTS - 1, 341, 682, 512};
		foreach (ring[i])
			on_ring[ring[i]] = 1'b1;
		while (ring.size() < 12) begin
			p = $urandom_range(MAX_POINTS - 1);
			if (!on_ring[p]) begin
				ring = {ring, p};
				on_ring[p] = 1'b1;
			end
		end
		for (int i = ring.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = ring[i];
			ring[i] = ring[j];
			ring[j] = t;
		end
		foreach (ring[i])
			send_item(OP_LOAD, ring[i], $urandom_range(MAX_POINTS - 1), i == ring.size() - 1);
	endtask

	task automatic test_query_nop();
		send_item(OP_QUERY, 0, $urandom_range(MAX_POINTS - 1), 1'b1);
		send_item(OP_QUERY, MAX_POINTS - 1, $urandom_range(MAX_POINTS - 1), 1'b0);
		send_item(OP_NOP, MAX_POINTS - 1, MAX_POINTS - 1, 1'b1);
	endtask

	task automatic test_moves();
		int b;
		b = ring_point();
		while (!move_ok(MAX_POINTS - 1, b))
			b = ring_point();
		send_item(OP_MOVE, MAX_POINTS - 1, b, 1'b0);
		send_item(OP_QUERY, MAX_POINTS - 1, 0, 1'b0);
		b = ring_point();
		while (!move_ok(0, b))
			b = ring_point();
		send_item(OP_MOVE, 0, b, 1'b1);
		send_item(OP_QUERY, 0, MAX_POINTS - 1, 1'b0);
	endtask

	// Reloading tour points finds their slots full; fresh points keep partial links.
	task automatic test_full_slot();
		send_item(OP_LOAD, ring[0], $urandom_range(MAX_POINTS - 1), 1'b0);
		send_item(OP_LOAD, ring[3], $urandom_range(MAX_POINTS - 1), 1'b0);
		send_item(OP_LOAD, fresh_point(), $urandom_range(MAX_POINTS - 1), 1'b0);
		send_item(OP_LOAD, fresh_point(), $urandom_range(MAX_POINTS - 1), 1'b1);
	endtask

	task automatic test_random_tour(int count);
		int kind;
		int a;
		int b;
		for (int n = 0; n < count; n++) begin
			idle_on = !(n >= 60 && n < 130);
			if (n == 150)
				await_all_results();
			kind = $urandom_range(99);
			if (kind < 45) begin
				a = ring_point();
				b = ring_point();
				while (!move_ok(a, b)) begin
					a = ring_point();
					b = ring_point();
				end
				send_item(OP_MOVE, a, b, $urandom_range(1));
			end else if (kind < 80) begin
				send_item(OP_QUERY, ring_point(), $urandom_range(MAX_POINTS - 1),
					$urandom_range(1));
			end else if (kind < 85) begin
				send_item(OP_NOP, $urandom_range(MAX_POINTS - 1),
					$urandom_range(MAX_POINTS - 1), $urandom_range(1));
			end else begin
				send_item(OP_LOAD, $urandom_range(MAX_POINTS - 1),
					$urandom_range(MAX_POINTS - 1), $urandom_range(4) == 0);
			end
		end
		idle_on = 1'b1;
	endtask

	// A move of a point onto itself breaks the ring; later walks may stop early.
	task automatic test_broken_tour();
		int a;
		int kind;
		a = ring_point();
		send_item(OP_MOVE, a, a, 1'b0);
		send_item(OP_QUERY, a, $urandom_range(MAX_POINTS - 1), 1'b0);
		for (int n = 0; n < 24; n++) begin
			kind = $urandom_range(99);
			if (kind < 40)
				send_item(OP_MOVE, known_point(), known_point(), $urandom_range(1));
			else if (kind < 80)
				send_item(OP_QUERY, known_point(), $urandom_range(MAX_POINTS - 1), 1'b0);
			else if (kind < 90)
				send_item(OP_LOAD, $urandom_range(MAX_POINTS - 1), 0, $urandom_range(1));
			else
				send_item(OP_NOP, 0, 0, 1'b0);
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			adj_lo[i] = NO_POINT;
			adj_hi[i] = NO_POINT;
			succ_of[i] = '0;
			succ_known[i] = 1'b0;
			on_ring[i] = 1'b0;
		end
		load_cnt = '0;
		tour_head = 0;
		tour_prev = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_tour_load();
		test_query_nop();
		test_moves();
		test_full_slot();
		test_random_tour(240);
		test_broken_tour();
		await_all_results();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && awaited_rsp.size() == 0)
			$display("[tour_two_opt_adjacency_engine_core] OK");
		else
			$display("[tour_two_opt_adjacency_engine_core] ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[tour_two_opt_adjacency_engine_core] ERROR");
		$finish;
	end

endmodule

// ===== tour_two_opt_adjacency_engine_core.f =====
src/tpo_pkg.sv
src/tpo_ram.sv
src/tpo_seq.sv
src/tour_two_opt_adjacency_engine_core.sv
src/tpo_chk.sv
verif/tb_tour_two_opt_adjacency_engine_core.sv
